[hw/rtl/ksts_pkg.sv]
// Shared widths, codes and defaults for the k-ary sorted table search block.
// No dependencies; compiled first.
package ksts_pkg;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int PROBES_DEF      = 4;

  localparam logic [IDX_W-1:0] LAST_INDEX_RST = 10'd1023;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

endpackage

[hw/rtl/ksts_if.sv]
// Valid/ready channel interfaces: input items, results and the config write.
// Depends on ksts_pkg for field widths.
interface ksts_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic        [ksts_pkg::IDX_W-1:0]   entry_index;
  logic signed [ksts_pkg::DATA_W-1:0]  entry_value;
  logic signed [ksts_pkg::DATA_W-1:0]  search_key;

  modport source (output valid, kind, entry_index, entry_value, search_key, input ready);
  modport sink   (input valid, kind, entry_index, entry_value, search_key, output ready);
endinterface

interface ksts_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [ksts_pkg::IDX_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface ksts_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ksts_pkg::IDX_W-1:0] last_index;

  modport source (output valid, last_index, input ready);
  modport sink   (input valid, last_index, output ready);
endinterface

[hw/rtl/ksts_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Defaults from ksts_pkg.
module ksts_ram #(
  parameter int WIDTH = ksts_pkg::DATA_W,
  parameter int DEPTH = ksts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/k_ary_sorted_table_search.sv]
// K-ary search over a sorted table held in one single-port-read RAM.
// Load word: accepted in idle, written to the RAM that cycle, no result.
// Search word: each round is a plan state, then probe reads (one RAM read per
// cycle, each compared in the cycle after its read); then binary finish, a read
// and a compare state per step, and a done state to hand off to the output.
// One word in flight; a result waits in the output register while the next is taken.
// Reset (rst_n, sync): idle, output empty, last_index = 1023; table contents undefined.
module k_ary_sorted_table_search #(
  parameter int TABLE_DEPTH = ksts_pkg::TABLE_DEPTH_DEF,
  parameter int PROBES      = ksts_pkg::PROBES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ksts_in_if.sink          in_ch,
  ksts_out_if.source       out_ch,
  ksts_cfg_if.sink         cfg_ch
);
  import ksts_pkg::*;

  localparam int MEM_DEPTH = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int WW        = IDX_W + 1;
  localparam int CNT_W     = $clog2(PROBES + 1);
  // floor(n / PROBES) for n < 2**IDX_W as (n * DIV_M) >> DIV_SH
  localparam int DIV_L     = $clog2(PROBES);
  localparam int DIV_SH    = IDX_W + DIV_L;
  localparam int DIV_M     = ((1 << DIV_SH) + PROBES - 1) / PROBES;
  localparam int PROD_W    = DIV_SH + IDX_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_PLAN    = 6'b000010,
    S_PROBE   = 6'b000100,
    S_BIN_RD  = 6'b001000,
    S_BIN_CMP = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] last_index_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [IDX_W-1:0] out_pos_r, out_pos_nxt;

  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic [WW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [WW-1:0]    issue_p_r, issue_p_nxt;
  logic [CNT_W-1:0] issue_cnt_r, issue_cnt_nxt;
  logic [CNT_W-1:0] cmp_cnt_r, cmp_cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [WW-1:0]    pend_p_r, pend_p_nxt;
  logic [WW-1:0]    prev_p_r, prev_p_nxt;
  logic             prev_gt_r, prev_gt_nxt;
  logic             gt0_r, gt0_nxt;
  logic             flip_r, flip_nxt;
  logic [WW-1:0]    flip_lo_r, flip_lo_nxt, flip_hi_r, flip_hi_nxt;
  logic [WW-1:0]    mid_r, mid_nxt;
  logic             res_found_r, res_found_nxt;
  logic [IDX_W-1:0] res_pos_r, res_pos_nxt;

  logic                     in_acc;
  logic                     ram_we;
  logic                     rd_en;
  logic [WW-1:0]            rd_addr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_data;
  logic [WW-1:0]            width;
  logic [PROD_W-1:0]        prod;
  logic [IDX_W-1:0]         hi_init;
  logic [WW-1:0]            mid_calc;
  logic                     gt;
  logic                     new_flip;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;

  // Loads only land in idle and searches only read outside idle: no RAM hazard.
  assign ram_we = in_acc && (in_ch.kind == KIND_LOAD) &&
                  ({1'b0, in_ch.entry_index} < WW'(MEM_DEPTH));

  assign rd_data  = $signed(ram_rdata);
  assign width    = hi_r - lo_r;
  assign prod     = PROD_W'(width[IDX_W-1:0]) * PROD_W'(DIV_M);
  assign hi_init  = (last_index_r > IDX_W'(MEM_DEPTH - 1)) ? IDX_W'(MEM_DEPTH - 1) : last_index_r;
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign gt       = key_r > rd_data;
  assign new_flip = pend_r && (cmp_cnt_r != '0) && !flip_r && (gt != prev_gt_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = issue_p_r;
    if (state_r == S_PROBE && issue_cnt_r < CNT_W'(PROBES)) begin
      rd_en = 1'b1;
    end else if (state_r == S_BIN_RD && lo_r <= hi_r) begin
      rd_en   = 1'b1;
      rd_addr = mid_calc;
    end
  end

  ksts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.entry_index[AW-1:0]),
    .wdata (in_ch.entry_value),
    .re    (rd_en),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    step_nxt      = step_r;
    issue_p_nxt   = issue_p_r;
    issue_cnt_nxt = issue_cnt_r;
    cmp_cnt_nxt   = cmp_cnt_r;
    pend_nxt      = (state_r == S_PROBE) && (issue_cnt_r < CNT_W'(PROBES));
    pend_p_nxt    = issue_p_r;
    prev_p_nxt    = prev_p_r;
    prev_gt_nxt   = prev_gt_r;
    gt0_nxt       = gt0_r;
    flip_nxt      = flip_r;
    flip_lo_nxt   = flip_lo_r;
    flip_hi_nxt   = flip_hi_r;
    mid_nxt       = mid_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.kind == KIND_SEARCH) begin
          key_nxt   = in_ch.search_key;
          lo_nxt    = '0;
          hi_nxt    = {1'b0, hi_init};
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        step_nxt      = prod[DIV_SH +: IDX_W];
        issue_p_nxt   = lo_r;
        issue_cnt_nxt = '0;
        cmp_cnt_nxt   = '0;
        flip_nxt      = 1'b0;
        if (width >= WW'(PROBES + 4)) begin
          state_nxt = S_PROBE;
        end else begin
          state_nxt = S_BIN_RD;
        end
      end
      S_PROBE: begin
        if (issue_cnt_r < CNT_W'(PROBES)) begin
          issue_p_nxt   = issue_p_r + WW'(step_r);
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end
        if (pend_r) begin
          prev_gt_nxt = gt;
          prev_p_nxt  = pend_p_r;
          cmp_cnt_nxt = cmp_cnt_r + 1'b1;
          if (cmp_cnt_r == '0) begin
            gt0_nxt = gt;
          end
          if (new_flip) begin
            flip_nxt    = 1'b1;
            flip_lo_nxt = prev_p_r;
            flip_hi_nxt = pend_p_r;
          end
          if (rd_data == key_r) begin
            res_found_nxt = 1'b1;
            res_pos_nxt   = pend_p_r[IDX_W-1:0];
            state_nxt     = S_DONE;
          end else if (cmp_cnt_r == CNT_W'(PROBES - 1)) begin
            // round over: narrow to first flip, else miss or start at the last probe
            if (new_flip) begin
              lo_nxt    = prev_p_r;
              hi_nxt    = pend_p_r;
              state_nxt = S_PLAN;
            end else if (flip_r) begin
              lo_nxt    = flip_lo_r;
              hi_nxt    = flip_hi_r;
              state_nxt = S_PLAN;
            end else if (!gt0_r) begin
              res_found_nxt = 1'b0;
              res_pos_nxt   = '0;
              state_nxt     = S_DONE;
            end else begin
              lo_nxt    = pend_p_r;
              state_nxt = S_PLAN;
            end
          end
        end
      end
      S_BIN_RD: begin
        if (lo_r <= hi_r) begin
          mid_nxt   = mid_calc;
          state_nxt = S_BIN_CMP;
        end else begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_DONE;
        end
      end
      S_BIN_CMP: begin
        if (rd_data == key_r) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r[IDX_W-1:0];
          state_nxt     = S_DONE;
        end else if (!gt) begin
          if (mid_r == lo_r) begin
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = S_DONE;
          end else begin
            hi_nxt    = mid_r - 1'b1;
            state_nxt = S_BIN_RD;
          end
        end else begin
          lo_nxt    = mid_r + 1'b1;
          state_nxt = S_BIN_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      last_index_r <= LAST_INDEX_RST;
      pend_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        last_index_r <= cfg_ch.last_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    step_r      <= step_nxt;
    issue_p_r   <= issue_p_nxt;
    issue_cnt_r <= issue_cnt_nxt;
    cmp_cnt_r   <= cmp_cnt_nxt;
    pend_p_r    <= pend_p_nxt;
    prev_p_r    <= prev_p_nxt;
    prev_gt_r   <= prev_gt_nxt;
    gt0_r       <= gt0_nxt;
    flip_r      <= flip_nxt;
    flip_lo_r   <= flip_lo_nxt;
    flip_hi_r   <= flip_hi_nxt;
    mid_r       <= mid_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
  end

  // a miss always reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_pos_r == '0)
    else $error("miss with nonzero position");

  // handing off a result always leaves a valid word in the output register
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_valid_r || out_ch.ready) |=> out_valid_r && state_r == S_IDLE)
    else $error("result lost at hand-off");

  // table writes and search reads never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && rd_en))
    else $error("RAM write during search read");

  // compares never run ahead of the reads that feed them
  a_cmp_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> cmp_cnt_r <= issue_cnt_r)
    else $error("probe compare without a read");

  // a k-ary round only runs on a window inside the table
  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> lo_r <= hi_r && hi_r < WW'(MEM_DEPTH))
    else $error("probe window out of range");

endmodule
